// ===== hdl/light_gate_speed_timer_assert.svh =====
// Assertion macros used by the speed timer controller.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef LIGHT_GATE_SPEED_TIMER_ASSERT_SVH
`define LIGHT_GATE_SPEED_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
`define LGST_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("speed timer assertion failed");
`define LGST_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("speed timer assertion failed");
`else
`define LGST_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define LGST_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== hdl/lgst_pkg.sv =====
// Package of the light gate speed timer: constants, payload structs,
// controller state type and the command and status structs. No dependencies.
package lgst_pkg;

   localparam int DIST_BITS          = 16;
   localparam int STEP_BITS          = $clog2(DIST_BITS);
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [DIST_BITS-1:0] DIST_RESET = 16'd5000;
   localparam logic [DIST_BITS-1:0] SPEED_SAT  = 16'hFFFF;
   localparam logic [3:0]           DIGIT_TOP  = 4'd9;
   localparam logic [STEP_BITS-1:0] STEP_LAST  = STEP_BITS'(DIST_BITS - 1);

   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_SAMPLE   = 1'b1;
   localparam logic GATE_BROKEN = 1'b0;

   // Register index as decoded from address bit 2.
   localparam logic REG_SCALED_DISTANCE = 1'b0;

   typedef struct packed {
      logic op;
      logic gate_a_level;
      logic gate_b_level;
   } req_type;

   typedef struct packed {
      logic        running;
      logic [15:0] elapsed_ticks;
      logic [7:0]  seconds_digit;
      logic [3:0]  tenths_digit;
      logic [3:0]  hundredths_digit;
      logic [3:0]  thousandths_digit;
      logic        speed_valid;
      logic [15:0] speed_value;
      logic        divide_by_zero;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic exec_simple;
      logic div_start;
      logic div_step;
      logic div_finish;
   } cmd_type;

   typedef struct packed {
      logic hold_valid;
      logic hold_stop;
      logic out_free;
      logic rsp_pending;
   } stat_type;

endpackage

// ===== hdl/lgst_ctrl.sv =====
// Controller of the speed timer: sequences simple requests and the serial
// divide. Depends on lgst_pkg and light_gate_speed_timer_assert.svh.
`include "light_gate_speed_timer_assert.svh"

module lgst_ctrl
   import lgst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type             state_ff, state_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  step_last;

   assign step_last = (step_ff == STEP_LAST);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.hold_valid && stat.out_free && stat.hold_stop) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (step_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (stat.hold_valid && stat.out_free) begin
               cmd.div_start   = stat.hold_stop;
               cmd.exec_simple = !stat.hold_stop;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.div_finish = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.div_start) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   `LGST_ASSERT_IMPLIES(a_divide_has_request, clock, reset, state_ff != ST_IDLE, stat.hold_valid)
   `LGST_ASSERT_NEXT(a_start_enters_divide, clock, reset, cmd.div_start, state_ff == ST_DIVIDE)
   `LGST_ASSERT_IMPLIES(a_finish_output_empty, clock, reset, state_ff == ST_FINISH, !stat.rsp_pending)

endmodule

// ===== hdl/lgst_dp.sv =====
// Datapath of the speed timer: request holding register, timing counters,
// serial restoring divider, distance register and result register.
// Depends on lgst_pkg.
module lgst_dp
   import lgst_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  req_type              req_data,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 cfg_we,
   input  logic [DIST_BITS-1:0] cfg_wdata,
   output logic [DIST_BITS-1:0] cfg_rdata,
   input  cmd_type              cmd,
   output stat_type             stat
);

   logic                  hold_valid_ff, hold_valid_in;
   req_type               hold_ff;
   logic                  accept, release_hold;

   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [7:0]            sec_ff, sec_in;
   logic [3:0]            tenth_ff, tenth_in;
   logic [3:0]            hund_ff, hund_in;
   logic [3:0]            thou_ff, thou_in;
   logic                  c_thou, c_hund, c_tenth;

   logic [DIST_BITS-1:0]  dist_ff;

   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [DIST_BITS-1:0]  quot_ff, quot_in;
   logic [COUNT_BITS-1:0] dvs_ff;
   logic [COUNT_BITS:0]   rem_shift, rem_diff;
   logic                  rem_ge;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign accept       = req_valid && !hold_valid_ff;
   assign release_hold = cmd.exec_simple || cmd.div_finish;
   assign req_stall    = hold_valid_ff;

   assign stat.hold_valid  = hold_valid_ff;
   assign stat.hold_stop   = (hold_ff.op == OP_SAMPLE) && (hold_ff.gate_b_level == GATE_BROKEN);
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;
   assign stat.rsp_pending = rsp_valid_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (release_hold) begin
         hold_valid_in = 1'b0;
      end
   end

   // Decimal cascade: a digit at nine or above rolls to zero and carries.
   assign c_thou  = (thou_ff >= DIGIT_TOP);
   assign c_hund  = (hund_ff >= DIGIT_TOP);
   assign c_tenth = (tenth_ff >= DIGIT_TOP);

   always_comb begin
      active_in = active_ff;
      tick_in   = tick_ff;
      sec_in    = sec_ff;
      tenth_in  = tenth_ff;
      hund_in   = hund_ff;
      thou_in   = thou_ff;
      if (cmd.div_start) begin
         active_in = 1'b0;
      end else if (cmd.exec_simple) begin
         priority if (hold_ff.op == OP_TICK) begin
            if (active_ff) begin
               tick_in = tick_ff + COUNT_BITS'(1);
               thou_in = c_thou ? 4'd0 : thou_ff + 4'd1;
               if (c_thou) begin
                  hund_in = c_hund ? 4'd0 : hund_ff + 4'd1;
                  if (c_hund) begin
                     tenth_in = c_tenth ? 4'd0 : tenth_ff + 4'd1;
                     if (c_tenth) begin
                        sec_in = sec_ff + 8'd1;
                     end
                  end
               end
            end
         end else if (hold_ff.gate_a_level == GATE_BROKEN) begin
            active_in = 1'b1;
            tick_in   = '0;
            sec_in    = '0;
            tenth_in  = '0;
            hund_in   = '0;
            thou_in   = '0;
         end else begin
            active_in = active_ff;
         end
      end
   end

   // One restoring step per cycle, most significant dividend bit first.
   assign rem_shift = {rem_ff, quot_ff[DIST_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign rem_ge    = (rem_shift >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (cmd.div_start) begin
         rem_in  = '0;
         quot_in = dist_ff;
      end else if (cmd.div_step) begin
         rem_in  = rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
         quot_in = {quot_ff[DIST_BITS-2:0], rem_ge};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.exec_simple || cmd.div_finish) begin
         rsp_valid_in             = 1'b1;
         rsp_in.running           = active_in;
         rsp_in.elapsed_ticks     = 16'(tick_in);
         rsp_in.seconds_digit     = sec_in;
         rsp_in.tenths_digit      = tenth_in;
         rsp_in.hundredths_digit  = hund_in;
         rsp_in.thousandths_digit = thou_in;
         rsp_in.speed_valid       = cmd.div_finish;
         rsp_in.divide_by_zero    = cmd.div_finish && (dvs_ff == '0);
         if (!cmd.div_finish) begin
            rsp_in.speed_value = '0;
         end else if (dvs_ff == '0) begin
            rsp_in.speed_value = SPEED_SAT;
         end else begin
            rsp_in.speed_value = quot_ff;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         tick_ff       <= '0;
         sec_ff        <= '0;
         tenth_ff      <= '0;
         hund_ff       <= '0;
         thou_ff       <= '0;
         dist_ff       <= DIST_RESET;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         active_ff     <= active_in;
         tick_ff       <= tick_in;
         sec_ff        <= sec_in;
         tenth_ff      <= tenth_in;
         hund_ff       <= hund_in;
         thou_ff       <= thou_in;
         if (cfg_we) begin
            dist_ff <= cfg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= req_data;
      end
      if (cmd.div_start) begin
         dvs_ff <= tick_ff;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cfg_rdata = dist_ff;

endmodule

// ===== hdl/light_gate_speed_timer.sv =====
// A tick or start/idle sample goes from the request register to the result register;
// a stop sample runs the sixteen-step serial divider on the way, then the finish state.
// The request register frees when the result is written; a new request waits until then.
// A one-entry request register takes the next request while a result still waits.
// Reset is synchronous and active high: timing stops, all counts clear and the
// scaled distance returns to 5000. Depends on lgst_pkg, lgst_ctrl and lgst_dp.
module light_gate_speed_timer
   import lgst_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel.
   input  logic                     req_valid,
   input  req_type                  req_data,
   output logic                     req_stall,
   // Result channel.
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     rsp_stall,
   // Register port.
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // The controller and the datapath talk only through these two structs.
   cmd_type              cmd;
   stat_type             stat;
   logic                 cfg_we;
   logic                 reg_hit;
   logic [DIST_BITS-1:0] cfg_rdata;

   // The register port never waits. The single register sits at byte address
   // zero; address bit two selects the register, so the low bits are ignored
   // and any address with bit two set falls outside the register list.
   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_SCALED_DISTANCE);
   assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
   assign prdata  = reg_hit ? CSR_DATA_BITS'(cfg_rdata) : '0;

   // The controller picks up a held request once the result register can take
   // a new value, and runs the divider for stop samples.
   lgst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath keeps the timing state, the divider and the result register.
   lgst_dp #(
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cfg_we    (cfg_we),
      .cfg_wdata (pwdata[DIST_BITS-1:0]),
      .cfg_rdata (cfg_rdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
